FILE: design/csc_pkg.sv
// Shared types, constants and saturating arithmetic for the clock skew corrector.
// Used by csc_mul, csc_div and the top level; depends on nothing.
`default_nettype none
package csc_pkg;

  localparam int unsigned HistDepth = 64;
  localparam int unsigned FracBits  = 24;
  localparam int unsigned PtrW      = $clog2(HistDepth);
  localparam int unsigned CntW      = $clog2(HistDepth + 1);
  localparam int unsigned DivW      = 64 + FracBits;
  localparam int unsigned DivCntW   = $clog2(DivW + 1);
  localparam int unsigned MulShift  = 32 - FracBits;
  localparam int unsigned CfgW      = 30;
  localparam int unsigned MinFacW   = 25;
  localparam int unsigned PairW     = 128;

  localparam logic [63:0] OneQ       = 64'd1 << FracBits;
  localparam logic [63:0] BackTol    = (OneQ + 64'd5000) / 64'd10000;
  localparam logic [63:0] ScaleFloor = (OneQ + 64'd50000) / 64'd100000;
  localparam logic signed [63:0] SMax = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SMin = 64'sh8000_0000_0000_0000;

  typedef enum logic [2:0] {
    REG_JUMP_LIMIT = 3'd0,
    REG_RUNAWAY    = 3'd1,
    REG_CHASE_THR  = 3'd2,
    REG_MIN_FACTOR = 3'd3,
    REG_WINDOW     = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CHASE_KEEP = 2'd0,
    CHASE_SLOW = 2'd1,
    CHASE_FAST = 2'd2
  } chase_e;

  typedef struct packed {
    logic               go;
    logic signed [63:0] a;
    logic [31:0]        m;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic signed [63:0] y;
  } mul_rsp_t;

  typedef struct packed {
    logic        go;
    logic [63:0] n;
    logic [63:0] d;
    logic [63:0] cap;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] q;
  } div_rsp_t;

  function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? SMin : SMax;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] ssub(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? SMin : SMax;
    return s[63:0];
  endfunction

  function automatic logic [63:0] mag(input logic signed [63:0] a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

  function automatic logic signed [63:0] with_sign(input logic [63:0] m, input logic neg);
    if (neg) return m[63] ? SMin : $signed(64'(-m));
    return m[63] ? SMax : $signed(m);
  endfunction

  // base + off around the ring; both operands stay below the depth
  function automatic logic [PtrW-1:0] ring_idx(input logic [PtrW-1:0] base,
                                               input logic [CntW-1:0] off);
    logic [CntW:0] s;
    s = (CntW+1)'(base) + (CntW+1)'(off);
    if (s >= (CntW+1)'(HistDepth)) s = s - (CntW+1)'(HistDepth);
    return s[PtrW-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: design/csc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Holds the sample-pair history; no dependencies.
`default_nettype none
module csc_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: design/csc_mul.sv
// Fixed-point multiply a * m / 2^FracBits, truncated toward zero and saturated.
// One 32x32 multiplier used for two partial products; depends on csc_pkg.
`default_nettype none
module csc_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  csc_pkg::mul_req_t req_i,
  output csc_pkg::mul_rsp_t rsp_o
);

  typedef enum logic [1:0] {M_IDLE, M_HI, M_LO, M_FIN} mstate_e;

  mstate_e           st_q;
  logic [63:0]       x_q;
  logic              neg_q;
  logic [31:0]       m_q;
  logic [63:0]       ph_q, pl_q;
  csc_pkg::mul_rsp_t rsp_q;

  logic [31:0] opnd;
  logic [63:0] prod;
  logic        over;
  logic [63:0] top;
  logic [64:0] sum;
  logic [63:0] r;

  assign opnd = (st_q == M_HI) ? x_q[63:32] : x_q[31:0];
  assign prod = opnd * m_q;

  always_comb begin
    over = (ph_q >> (64 - csc_pkg::MulShift)) != '0;
    top  = ph_q << csc_pkg::MulShift;
    sum  = {1'b0, top} + {1'b0, pl_q >> csc_pkg::FracBits};
    r    = (over || sum[64]) ? '1 : sum[63:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= M_IDLE;
      rsp_q.done <= 1'b0;
    end else begin
      rsp_q.done <= 1'b0;
      unique case (st_q)
        M_IDLE: begin
          if (req_i.go) begin
            x_q   <= csc_pkg::mag(req_i.a);
            neg_q <= req_i.a[63];
            m_q   <= req_i.m;
            st_q  <= M_HI;
          end
        end
        M_HI: begin
          ph_q <= prod;
          st_q <= M_LO;
        end
        M_LO: begin
          pl_q <= prod;
          st_q <= M_FIN;
        end
        M_FIN: begin
          rsp_q.y    <= csc_pkg::with_sign(r, neg_q);
          rsp_q.done <= 1'b1;
          st_q       <= M_IDLE;
        end
        default: st_q <= M_IDLE;
      endcase
    end
  end

  assign rsp_o = rsp_q;

endmodule
`default_nettype wire

FILE: design/csc_div.sv
// Restoring divider: min(floor(n * 2^FracBits / d), cap), cap when d is zero.
// One quotient bit per cycle; depends on csc_pkg.
`default_nettype none
module csc_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  csc_pkg::div_req_t req_i,
  output csc_pkg::div_rsp_t rsp_o
);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_e;

  dstate_e                        st_q;
  logic [csc_pkg::DivW-1:0]       num_q;
  logic [63:0]                    rem_q;
  logic [63:0]                    d_q;
  logic [63:0]                    cap_q;
  logic [csc_pkg::DivCntW-1:0]    cnt_q;
  csc_pkg::div_rsp_t              rsp_q;

  logic [64:0] rsh;
  logic        fits;
  logic [64:0] rdif;

  always_comb begin
    rsh  = {rem_q, num_q[csc_pkg::DivW-1]};
    fits = rsh >= {1'b0, d_q};
    rdif = rsh - {1'b0, d_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= D_IDLE;
      rsp_q.done <= 1'b0;
    end else begin
      rsp_q.done <= 1'b0;
      unique case (st_q)
        D_IDLE: begin
          if (req_i.go) begin
            num_q <= {req_i.n, {csc_pkg::FracBits{1'b0}}};
            rem_q <= '0;
            d_q   <= req_i.d;
            cap_q <= req_i.cap;
            cnt_q <= csc_pkg::DivCntW'(csc_pkg::DivW);
            st_q  <= D_RUN;
          end
        end
        D_RUN: begin
          rem_q <= fits ? rdif[63:0] : rsh[63:0];
          num_q <= {num_q[csc_pkg::DivW-2:0], fits};
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == csc_pkg::DivCntW'(1)) st_q <= D_FIN;
        end
        D_FIN: begin
          if (d_q == '0 || num_q > csc_pkg::DivW'(cap_q)) rsp_q.q <= cap_q;
          else rsp_q.q <= num_q[63:0];
          rsp_q.done <= 1'b1;
          st_q       <= D_IDLE;
        end
        default: st_q <= D_IDLE;
      endcase
    end
  end

  assign rsp_o = rsp_q;

endmodule
`default_nettype wire

FILE: design/clock_skew_corrector.sv
// Clock skew corrector top level: sequencer, offsets, scale and history ring.
// Depends on csc_pkg, csc_ram, csc_mul and csc_div.
//
// Usage: each transfer on the s_axis channel carries one sample pair (raw timer
// and wall clock, signed Q39.24). The block answers each sample with exactly
// one transfer on m_axis carrying the corrected time, a jump flag, the chase
// state, the saturating jump count and the current rate scale.
// Registers are written on the cfg channel (always ready); the user must write
// them only while no sample is in flight, which the block does not enforce.
// An index beyond the five registers is ignored. A sample that needs a history
// walk or divisions takes longer than a quiet one: the divider is bit-serial, and
// the history walk over the ring RAM does one read and one write-back per entry
// through the single RAM port pair.
// One sample is processed at a time; s_axis_tready_o is high while the
// sequencer waits for a sample.
// Results sit in an output register: the next sample is accepted while a
// result waits; if the receiver still stalls when the following result is
// done, the sequencer holds until the register drains.
// Reset clears the control state, not the ring RAM: entry zero of the ring reads
// as zero until first written, so no clearing pass runs.
`default_nettype none
module clock_skew_corrector (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // tdata: raw_time [63:0], wall_time [127:64]
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  logic [127:0]             s_axis_tdata_i,
  // tdata: corr_time [63:0], jump_seen [64], chase_state [66:65],
  //        jump_count [98:67], rate_scale [130:99], zero [135:131]
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  output logic [135:0]             m_axis_tdata_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [2:0]               cfg_index_i,
  input  logic [csc_pkg::CfgW-1:0] cfg_data_i
);

  typedef enum logic [4:0] {
    S_IDLE, S_NEW, S_TD, S_CLS, S_JMP, S_RA, S_ADJ_RD, S_ADJ_WR, S_PUSH,
    S_RUN, S_RUNW, S_RUNC, S_HALF, S_AGE, S_AGE2, S_SDIV, S_SM1, S_SM2,
    S_EXP_RD, S_EXP_CK, S_CT, S_CTW, S_CHASE, S_FAC, S_FDIV, S_CORR, S_OUT
  } state_e;

  state_e state_q;

  logic [csc_pkg::CfgW-1:0]    jl_q, rl_q, thr_q, win_q;
  logic [csc_pkg::MinFacW-1:0] minf_q;

  logic signed [63:0] t_q, w_q;
  logic [31:0]        scale_q, ns_q;
  logic signed [63:0] roff_q, woff_q;
  csc_pkg::chase_e    mode_q;
  logic [31:0]        jcnt_q;
  logic [csc_pkg::PtrW-1:0] head_q, k_q;
  logic [csc_pkg::CntW-1:0] cnt_q, idx_q;
  logic               e0_q, zr_q, jump_q;
  logic signed [63:0] td_q, wd_q, ta_q, wa_q, ra_q, ct_q, cw_q, sk_q, tage_q, dage_q;

  logic               ov_q, ov_d;
  logic [135:0]       odata_q;

  csc_pkg::mul_req_t  mul_req_q;
  csc_pkg::mul_rsp_t  mul_rsp;
  csc_pkg::div_req_t  div_req_q;
  csc_pkg::div_rsp_t  div_rsp;

  logic                      ram_we, ram_re;
  logic [csc_pkg::PtrW-1:0]  ram_waddr, ram_raddr;
  logic [csc_pkg::PairW-1:0] ram_wdata, ram_rdata;

  logic signed [63:0] hr, hw;
  logic signed [63:0] jl_s, rl_s, thr_s, win_s, winh_s;
  logic signed [63:0] gap, absg, nd, ta_c, wa_c;
  logic               jump_c;
  logic               full;
  logic [csc_pkg::PtrW-1:0] ph;
  logic [csc_pkg::CntW-1:0] pc;
  logic [csc_pkg::PtrW-1:0] pidx;
  logic [63:0]        fdiff, fmax;
  logic [31:0]        fac_c;

  csc_ram #(.WIDTH(csc_pkg::PairW), .DEPTH(csc_pkg::HistDepth)) u_hist (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  csc_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req_q),
    .rsp_o  (mul_rsp)
  );

  csc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req_q),
    .rsp_o  (div_rsp)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = odata_q;

  // entry zero reads as zero until its first write
  assign hr = zr_q ? 64'sd0 : $signed(ram_rdata[63:0]);
  assign hw = zr_q ? 64'sd0 : $signed(ram_rdata[127:64]);

  assign jl_s   = $signed({34'b0, jl_q});
  assign rl_s   = $signed({34'b0, rl_q});
  assign thr_s  = $signed({34'b0, thr_q});
  assign win_s  = $signed({34'b0, win_q});
  assign winh_s = $signed({35'b0, win_q[csc_pkg::CfgW-1:1]});

  // jump classification and clamp amounts
  always_comb begin
    gap    = csc_pkg::ssub(td_q, wd_q);
    absg   = gap[63] ? csc_pkg::with_sign(csc_pkg::mag(gap), 1'b0) : gap;
    jump_c = (td_q < -$signed(csc_pkg::BackTol)) || (absg > jl_s);
    nd     = 64'sd0;
    if (td_q[63] && wd_q[63]) begin
      ta_c = csc_pkg::ssub(64'sd0, td_q);
      wa_c = csc_pkg::ssub(64'sd0, wd_q);
    end else begin
      if (td_q[63] || (!wd_q[63] && wd_q < td_q)) nd = (wd_q < jl_s) ? wd_q : jl_s;
      else nd = (td_q < jl_s) ? td_q : jl_s;
      ta_c = csc_pkg::ssub(nd, td_q);
      wa_c = csc_pkg::ssub(nd, wd_q);
    end
  end

  // ring push: drop the oldest pair when full
  always_comb begin
    full = cnt_q >= csc_pkg::CntW'(csc_pkg::HistDepth);
    ph   = full ? csc_pkg::ring_idx(head_q, csc_pkg::CntW'(1)) : head_q;
    pc   = full ? csc_pkg::CntW'(csc_pkg::HistDepth - 1) : cnt_q;
    pidx = csc_pkg::ring_idx(ph, pc);
  end

  // chase slide factor from the reciprocal of the skew
  always_comb begin
    fdiff = csc_pkg::OneQ - div_rsp.q;
    fmax  = (fdiff < {39'b0, minf_q}) ? {39'b0, minf_q} : fdiff;
    fac_c = (fmax > 64'hFFFF_FFFF) ? '1 : fmax[31:0];
  end

  // output register: drain on transfer, load when a result is ready
  always_comb begin
    ov_d = ov_q && !m_axis_tready_i;
    if (state_q == S_OUT && (!ov_q || m_axis_tready_i)) ov_d = 1'b1;
  end

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = head_q;
    ram_we    = 1'b0;
    ram_waddr = pidx;
    ram_wdata = {w_q, t_q};
    unique case (state_q)
      S_IDLE: begin
        ram_re    = s_axis_tvalid_i;
        ram_raddr = csc_pkg::ring_idx(head_q, cnt_q - 1'b1);
      end
      S_CLS: ram_re = 1'b1;
      S_ADJ_RD: begin
        ram_re    = 1'b1;
        ram_raddr = csc_pkg::ring_idx(head_q, idx_q);
      end
      S_ADJ_WR: begin
        ram_we    = 1'b1;
        ram_waddr = k_q;
        ram_wdata = {csc_pkg::ssub(hw, wa_q), csc_pkg::ssub(hr, ra_q)};
      end
      S_PUSH:   ram_we = 1'b1;
      S_EXP_RD: ram_re = (cnt_q != '0);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      jl_q         <= 30'd33554432;
      rl_q         <= 30'd16777216;
      thr_q        <= 30'd8388608;
      minf_q       <= 25'd1677722;
      win_q        <= 30'd50331648;
      scale_q      <= csc_pkg::OneQ[31:0];
      roff_q       <= '0;
      woff_q       <= '0;
      mode_q       <= csc_pkg::CHASE_KEEP;
      jcnt_q       <= '0;
      head_q       <= '0;
      cnt_q        <= csc_pkg::CntW'(1);
      e0_q         <= 1'b0;
      zr_q         <= 1'b0;
      jump_q       <= 1'b0;
      ov_q         <= 1'b0;
      mul_req_q.go <= 1'b0;
      div_req_q.go <= 1'b0;
    end else begin
      mul_req_q.go <= 1'b0;
      div_req_q.go <= 1'b0;
      ov_q         <= ov_d;
      if (ram_re) zr_q <= (ram_raddr == '0) && !e0_q;
      if (ram_we && ram_waddr == '0) e0_q <= 1'b1;

      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          csc_pkg::REG_JUMP_LIMIT: jl_q   <= cfg_data_i;
          csc_pkg::REG_RUNAWAY:    rl_q   <= cfg_data_i;
          csc_pkg::REG_CHASE_THR:  thr_q  <= cfg_data_i;
          csc_pkg::REG_MIN_FACTOR: minf_q <= cfg_data_i[csc_pkg::MinFacW-1:0];
          csc_pkg::REG_WINDOW:     win_q  <= cfg_data_i;
          default: ;
        endcase
      end

      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid_i) begin
            t_q     <= $signed(s_axis_tdata_i[63:0]);
            w_q     <= $signed(s_axis_tdata_i[127:64]);
            state_q <= S_NEW;
          end
        end
        S_NEW: begin
          mul_req_q.go <= 1'b1;
          mul_req_q.a  <= csc_pkg::ssub(t_q, hr);
          mul_req_q.m  <= scale_q;
          wd_q         <= csc_pkg::ssub(w_q, hw);
          state_q      <= S_TD;
        end
        S_TD: begin
          if (mul_rsp.done) begin
            td_q    <= mul_rsp.y;
            state_q <= S_CLS;
          end
        end
        S_CLS: begin
          jump_q <= jump_c;
          if (jump_c) begin
            if (jcnt_q != '1) jcnt_q <= jcnt_q + 1'b1;
            ta_q    <= ta_c;
            wa_q    <= wa_c;
            state_q <= S_JMP;
          end else if (!wd_q[63]) begin
            state_q <= S_AGE;
          end else begin
            state_q <= S_CT;
          end
        end
        S_JMP: begin
          roff_q        <= csc_pkg::sadd(roff_q, ta_q);
          td_q          <= csc_pkg::sadd(td_q, ta_q);
          woff_q        <= csc_pkg::sadd(woff_q, wa_q);
          div_req_q.go  <= 1'b1;
          div_req_q.n   <= csc_pkg::mag(ta_q);
          div_req_q.d   <= {32'b0, (scale_q == '0) ? 32'd1 : scale_q};
          div_req_q.cap <= 64'h8000_0000_0000_0000;
          state_q       <= S_RA;
        end
        S_RA: begin
          if (div_rsp.done) begin
            ra_q    <= csc_pkg::with_sign(div_rsp.q, ta_q[63]);
            idx_q   <= '0;
            state_q <= S_ADJ_RD;
          end
        end
        S_ADJ_RD: begin
          k_q     <= csc_pkg::ring_idx(head_q, idx_q);
          state_q <= S_ADJ_WR;
        end
        S_ADJ_WR: begin
          idx_q   <= idx_q + 1'b1;
          state_q <= ((idx_q + 1'b1) < cnt_q) ? S_ADJ_RD : S_PUSH;
        end
        S_PUSH: begin
          head_q  <= ph;
          cnt_q   <= pc + 1'b1;
          state_q <= jump_q ? S_RUN : S_CT;
        end
        S_RUN: begin
          mul_req_q.go <= 1'b1;
          mul_req_q.a  <= t_q;
          mul_req_q.m  <= scale_q;
          state_q      <= S_RUNW;
        end
        S_RUNW: begin
          if (mul_rsp.done) begin
            ct_q    <= csc_pkg::sadd(mul_rsp.y, roff_q);
            cw_q    <= csc_pkg::sadd(w_q, woff_q);
            state_q <= S_RUNC;
          end
        end
        S_RUNC: begin
          // runaway after a jump: halve the scale
          if (csc_pkg::ssub(ct_q, cw_q) > rl_s && {32'b0, scale_q} > csc_pkg::ScaleFloor) begin
            mul_req_q.go <= 1'b1;
            mul_req_q.a  <= t_q;
            mul_req_q.m  <= scale_q >> 1;
            state_q      <= S_HALF;
          end else begin
            state_q <= S_CT;
          end
        end
        S_HALF: begin
          if (mul_rsp.done) begin
            roff_q  <= csc_pkg::ssub(ct_q, mul_rsp.y);
            scale_q <= scale_q >> 1;
            state_q <= S_CT;
          end
        end
        S_AGE: begin
          tage_q  <= csc_pkg::ssub(t_q, hr);
          dage_q  <= csc_pkg::ssub(w_q, hw);
          state_q <= S_AGE2;
        end
        S_AGE2: begin
          if (dage_q > winh_s && tage_q > 64'sd0) begin
            div_req_q.go  <= 1'b1;
            div_req_q.n   <= dage_q;
            div_req_q.d   <= tage_q;
            div_req_q.cap <= 64'hFFFF_FFFF;
            state_q       <= S_SDIV;
          end else if (dage_q > win_s) begin
            state_q <= S_EXP_RD;
          end else begin
            state_q <= S_PUSH;
          end
        end
        S_SDIV: begin
          if (div_rsp.done) begin
            ns_q         <= (div_rsp.q == '0) ? 32'd1 : div_rsp.q[31:0];
            mul_req_q.go <= 1'b1;
            mul_req_q.a  <= t_q;
            mul_req_q.m  <= scale_q;
            state_q      <= S_SM1;
          end
        end
        S_SM1: begin
          if (mul_rsp.done) begin
            ct_q         <= csc_pkg::sadd(mul_rsp.y, roff_q);
            mul_req_q.go <= 1'b1;
            mul_req_q.a  <= t_q;
            mul_req_q.m  <= ns_q;
            state_q      <= S_SM2;
          end
        end
        S_SM2: begin
          if (mul_rsp.done) begin
            roff_q  <= csc_pkg::ssub(ct_q, mul_rsp.y);
            scale_q <= ns_q;
            state_q <= (dage_q > win_s) ? S_EXP_RD : S_PUSH;
          end
        end
        S_EXP_RD: begin
          state_q <= (cnt_q == '0) ? S_PUSH : S_EXP_CK;
        end
        S_EXP_CK: begin
          // expire the oldest pair while it lies outside the window
          if (csc_pkg::ssub(w_q, hw) > win_s) begin
            head_q  <= csc_pkg::ring_idx(head_q, csc_pkg::CntW'(1));
            cnt_q   <= cnt_q - 1'b1;
            state_q <= S_EXP_RD;
          end else begin
            state_q <= S_PUSH;
          end
        end
        S_CT: begin
          mul_req_q.go <= 1'b1;
          mul_req_q.a  <= t_q;
          mul_req_q.m  <= scale_q;
          state_q      <= S_CTW;
        end
        S_CTW: begin
          if (mul_rsp.done) begin
            ct_q    <= csc_pkg::sadd(mul_rsp.y, roff_q);
            cw_q    <= csc_pkg::sadd(w_q, woff_q);
            state_q <= S_CHASE;
          end
        end
        S_CHASE: begin
          case (mode_q)
            csc_pkg::CHASE_SLOW: begin
              if (ct_q < cw_q) begin
                mode_q  <= csc_pkg::CHASE_KEEP;
                state_q <= S_OUT;
              end else begin
                sk_q    <= csc_pkg::ssub(ct_q, cw_q);
                state_q <= S_FAC;
              end
            end
            csc_pkg::CHASE_FAST: begin
              if (ct_q > cw_q) begin
                mode_q  <= csc_pkg::CHASE_KEEP;
                state_q <= S_OUT;
              end else begin
                sk_q    <= csc_pkg::ssub(cw_q, ct_q);
                state_q <= S_FAC;
              end
            end
            default: begin
              if (csc_pkg::ssub(cw_q, ct_q) > thr_s) mode_q <= csc_pkg::CHASE_FAST;
              else if (csc_pkg::ssub(ct_q, cw_q) > thr_s) mode_q <= csc_pkg::CHASE_SLOW;
              else mode_q <= csc_pkg::CHASE_KEEP;
              state_q <= S_OUT;
            end
          endcase
        end
        S_FAC: begin
          if (sk_q > $signed(csc_pkg::OneQ)) begin
            div_req_q.go  <= 1'b1;
            div_req_q.n   <= csc_pkg::OneQ;
            div_req_q.d   <= sk_q;
            div_req_q.cap <= csc_pkg::OneQ;
            state_q       <= S_FDIV;
          end else begin
            mul_req_q.go <= 1'b1;
            mul_req_q.a  <= td_q;
            mul_req_q.m  <= {7'b0, minf_q};
            state_q      <= S_CORR;
          end
        end
        S_FDIV: begin
          if (div_rsp.done) begin
            mul_req_q.go <= 1'b1;
            mul_req_q.a  <= td_q;
            mul_req_q.m  <= fac_c;
            state_q      <= S_CORR;
          end
        end
        S_CORR: begin
          if (mul_rsp.done) begin
            if (mode_q == csc_pkg::CHASE_SLOW) begin
              roff_q <= csc_pkg::ssub(roff_q, mul_rsp.y);
              ct_q   <= csc_pkg::ssub(ct_q, mul_rsp.y);
            end else begin
              roff_q <= csc_pkg::sadd(roff_q, mul_rsp.y);
              ct_q   <= csc_pkg::sadd(ct_q, mul_rsp.y);
            end
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!ov_q || m_axis_tready_i) begin
            odata_q <= {5'b0, scale_q, jcnt_q, mode_q, jump_q, ct_q};
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= csc_pkg::CntW'(csc_pkg::HistDepth))
    else $error("history count beyond depth");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> (state_q == S_NEW))
    else $error("accepted sample did not start processing");

  a_jcnt_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (jcnt_q >= $past(jcnt_q)))
    else $error("jump count decreased");

  a_scale_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scale_q != '0)
    else $error("rate scale became zero");

  a_jump_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && jump_q) |-> (jcnt_q != '0))
    else $error("jump reported without count");

endmodule
`default_nettype wire
